>>> rtl/assert_macros.svh
// Assertion macros used by the level meter RTL.
// Needs nothing else; included by the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/apm_pkg.sv
// Types and constants of the peak level meter.
// Standalone; used by apm_ctrl, apm_dp and audio_peak_meter_decay_hold.
`default_nettype none

package apm_pkg;

    localparam int LEVEL_BITS = 16;
    localparam int LEVEL_W    = LEVEL_BITS + 1;
    localparam int POS_W      = 10;
    localparam int TIMER_W    = 16;
    localparam int DECAY_W    = 8;

    localparam int MARGIN_PX  = 6;
    localparam int HOLD_FLOOR = 3;
    localparam int LOG_K_Q20  = 105218;
    localparam int K_W        = 17;
    localparam int FRAC_BITS  = 16;
    localparam int STEP_W     = $clog2(FRAC_BITS);

    // log2 datapath widths
    localparam int MANT_Q     = 30;
    localparam int MANT_W     = MANT_Q + 1;
    localparam int SQ_W       = 2 * MANT_W;
    localparam int D_W        = $clog2(LEVEL_BITS + 1);
    localparam int NL_W       = D_W + FRAC_BITS;
    localparam int SK_W       = POS_W + K_W;
    localparam int P_W        = SK_W + NL_W;
    localparam int LOG_SHIFT  = 36;
    localparam int S36_W      = POS_W + LOG_SHIFT;
    localparam int A_W        = ((P_W > S36_W) ? P_W : S36_W) + 1;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = {1'b1, {LEVEL_BITS{1'b0}}};

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_METER_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DB_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 3'd4;

    localparam logic [POS_W-1:0]   RST_METER_WIDTH = 10'd250;
    localparam logic [DECAY_W-1:0] RST_DECAY_STEP  = 8'd4;
    localparam logic [TIMER_W-1:0] RST_HOLD_TICKS  = 16'd3000;

    localparam logic KIND_LEVEL = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic               channel;
        logic [LEVEL_W-1:0] level;
    } t_in_item;

    typedef struct packed {
        logic             out_channel;
        logic [POS_W-1:0] bar_pos;
        logic [POS_W-1:0] hold_pos;
        logic             hold_reset;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic norm;
        logic sqr;
        logic acc;
        logic scale;
        logic prod;
        logic map;
        logic apply;
        logic tick;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic ch_ok;
        logic db;
        logic lvl_zero;
        logic normed;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/apm_ctrl.sv
// Sequencer of the peak level meter: accepts items and steps the datapath.
// Depends on apm_pkg.
`default_nettype none

module apm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire apm_pkg::t_dp_stat i_stat,
    output logic                   o_in_stall,
    output logic                   o_cfg_ready,
    output apm_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_DECODE = 10'b00_0000_0010,
        ST_NORM   = 10'b00_0000_0100,
        ST_SQR    = 10'b00_0000_1000,
        ST_ACC    = 10'b00_0001_0000,
        ST_SCALE  = 10'b00_0010_0000,
        ST_PROD   = 10'b00_0100_0000,
        ST_MAP    = 10'b00_1000_0000,
        ST_APPLY  = 10'b01_0000_0000,
        ST_TICK   = 10'b10_0000_0000
    } t_state;

    localparam logic [apm_pkg::STEP_W-1:0] STEP_LAST =
        apm_pkg::STEP_W'(apm_pkg::FRAC_BITS - 1);

    t_state                     r_state, n_state;
    logic [apm_pkg::STEP_W-1:0] r_step, n_step;
    logic                       w_idle;

    assign w_idle      = (r_state == ST_IDLE);
    assign o_in_stall  = !w_idle;
    assign o_cfg_ready = w_idle;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_stat.kind == apm_pkg::KIND_TICK) begin
                    n_state = ST_TICK;
                end else if (!i_stat.ch_ok) begin
                    n_state = ST_IDLE;
                end else if (!i_stat.db || i_stat.lvl_zero) begin
                    n_state = ST_MAP;
                end else begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (i_stat.normed) begin
                    n_step  = '0;
                    n_state = ST_SQR;
                end else begin
                    o_cmd.norm = 1'b1;
                end
            end
            ST_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_SCALE;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = ST_SQR;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = ST_MAP;
            end
            ST_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = ST_APPLY;
            end
            ST_APPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (i_stat.out_free) begin
                    o_cmd.tick = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

>>> rtl/apm_dp.sv
// Datapath of the peak level meter: registers, log2 unit, mapping, falloff, hold.
// Depends on apm_pkg; driven by apm_ctrl commands.
`default_nettype none

module apm_dp #(
    parameter int CHANNELS = 2
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire apm_pkg::t_in_item                 i_in_item,
    input  wire apm_pkg::t_dp_cmd                  i_cmd,
    output apm_pkg::t_dp_stat                      o_stat,
    input  wire logic                              i_cfg_we,
    input  wire logic [apm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [apm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output apm_pkg::t_out_item                     o_out_item
);

    localparam int LB  = apm_pkg::LEVEL_BITS;
    localparam int LW  = apm_pkg::LEVEL_W;
    localparam int PSW = apm_pkg::POS_W;

    localparam logic [PSW-1:0] MARGIN = PSW'(apm_pkg::MARGIN_PX);
    localparam logic [PSW-1:0] FLOOR  = PSW'(apm_pkg::HOLD_FLOOR);
    localparam logic [apm_pkg::K_W-1:0] LOG_K = apm_pkg::K_W'(apm_pkg::LOG_K_Q20);

    // item registers
    logic                           r_kind;
    logic                           r_ch;
    logic [LW-1:0]                  r_level;
    logic [apm_pkg::MANT_W-1:0]     r_mant;
    logic [apm_pkg::D_W-1:0]        r_d;
    logic [apm_pkg::FRAC_BITS-1:0]  r_frac;
    logic [apm_pkg::SQ_W-1:0]       r_prod;
    logic [apm_pkg::SK_W-1:0]       r_sk;
    logic [apm_pkg::NL_W-1:0]       r_nl;
    logic [apm_pkg::P_W-1:0]        r_p;
    logic [PSW-1:0]                 r_pos;

    // configuration
    logic [PSW-1:0]                 r_meter_width;
    logic                           r_db_mode;
    logic                           r_hold_en;
    logic [apm_pkg::DECAY_W-1:0]    r_decay;
    logic [apm_pkg::TIMER_W-1:0]    r_hold_ticks;

    // meter state
    logic [PSW-1:0]                 r_bar  [CHANNELS];
    logic [PSW-1:0]                 r_hold [CHANNELS];
    logic [apm_pkg::TIMER_W-1:0]    r_timer;
    logic                           r_running;

    logic                           r_out_valid;
    apm_pkg::t_out_item             r_out_item;

    logic [LW-1:0]                  w_lvl_sat;
    logic [PSW-1:0]                 w_span;
    logic [apm_pkg::SQ_W-apm_pkg::MANT_Q-1:0] w_sq;
    logic [LW+PSW-1:0]              w_lin;
    logic [apm_pkg::A_W-1:0]        w_diff;
    logic [PSW-1:0]                 w_map_pos;
    logic [PSW-1:0]                 w_old;
    logic [PSW-1:0]                 w_dropped;
    logic [PSW-1:0]                 w_bar;
    logic                           w_hold_up;
    logic [PSW-1:0]                 w_hold_out;
    logic [apm_pkg::TIMER_W-1:0]    w_t_next;
    logic [apm_pkg::TIMER_W-1:0]    w_limit;
    logic                           w_expire;
    logic                           w_out_free;

    assign w_lvl_sat = (i_in_item.level > apm_pkg::FULL_SCALE) ?
                       apm_pkg::FULL_SCALE : i_in_item.level;
    assign w_span    = (r_meter_width > MARGIN) ? (r_meter_width - MARGIN) : '0;
    assign w_sq      = r_prod[apm_pkg::SQ_W-1:apm_pkg::MANT_Q];
    assign w_lin     = r_level * w_span;
    assign w_diff    = apm_pkg::A_W'({w_span, {apm_pkg::LOG_SHIFT{1'b0}}})
                     - apm_pkg::A_W'(r_p);

    always_comb begin
        if (!r_db_mode) begin
            w_map_pos = w_lin[LB+PSW-1:LB];
        end else if (r_level == '0) begin
            w_map_pos = '0;
        end else if (w_diff[apm_pkg::A_W-1]) begin
            w_map_pos = FLOOR;
        end else begin
            w_map_pos = w_diff[apm_pkg::LOG_SHIFT+PSW-1:apm_pkg::LOG_SHIFT];
        end
    end

    // falloff and hold
    assign w_old     = r_bar[r_ch];
    assign w_dropped = (w_old > PSW'(r_decay)) ? (w_old - PSW'(r_decay)) : '0;
    assign w_bar     = (r_pos >= w_old) ? r_pos :
                       ((w_dropped > r_pos) ? w_dropped : r_pos);
    assign w_hold_up = r_hold_en && (w_bar > r_hold[r_ch]);
    assign w_hold_out = !r_hold_en ? '0 : (w_hold_up ? w_bar : r_hold[r_ch]);

    // hold timer
    assign w_t_next = r_timer + 1'b1;
    assign w_limit  = (r_hold_ticks == '0) ? apm_pkg::TIMER_W'(1) : r_hold_ticks;
    assign w_expire = r_running && (w_t_next >= w_limit);

    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_stat.kind     = r_kind;
    assign o_stat.ch_ok    = (int'(r_ch) < CHANNELS);
    assign o_stat.db       = r_db_mode;
    assign o_stat.lvl_zero = (r_level == '0);
    assign o_stat.normed   = r_mant[apm_pkg::MANT_W-1];
    assign o_stat.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in_item.kind;
            r_ch    <= i_in_item.channel;
            r_level <= w_lvl_sat;
            r_mant  <= {w_lvl_sat, {(apm_pkg::MANT_Q - LB){1'b0}}};
            r_d     <= '0;
            r_frac  <= '0;
        end
        if (i_cmd.norm) begin
            r_mant <= {r_mant[apm_pkg::MANT_W-2:0], 1'b0};
            r_d    <= r_d + 1'b1;
        end
        if (i_cmd.sqr) begin
            r_prod <= r_mant * r_mant;
        end
        if (i_cmd.acc) begin
            r_mant <= w_sq[apm_pkg::MANT_W] ? w_sq[apm_pkg::MANT_W:1]
                                            : w_sq[apm_pkg::MANT_W-1:0];
            r_frac <= {r_frac[apm_pkg::FRAC_BITS-2:0], w_sq[apm_pkg::MANT_W]};
        end
        if (i_cmd.scale) begin
            r_sk <= w_span * LOG_K;
            r_nl <= {r_d, {apm_pkg::FRAC_BITS{1'b0}}} - apm_pkg::NL_W'(r_frac);
        end
        if (i_cmd.prod) begin
            r_p <= r_sk * r_nl;
        end
        if (i_cmd.map) begin
            r_pos <= w_map_pos;
        end
        if (i_cmd.apply) begin
            r_out_item.out_channel <= r_ch;
            r_out_item.bar_pos     <= w_bar;
            r_out_item.hold_pos    <= w_hold_out;
            r_out_item.hold_reset  <= 1'b0;
        end else if (i_cmd.tick && w_expire) begin
            r_out_item.out_channel <= 1'b0;
            r_out_item.bar_pos     <= '0;
            r_out_item.hold_pos    <= FLOOR;
            r_out_item.hold_reset  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meter_width <= apm_pkg::RST_METER_WIDTH;
            r_db_mode     <= 1'b0;
            r_hold_en     <= 1'b1;
            r_decay       <= apm_pkg::RST_DECAY_STEP;
            r_hold_ticks  <= apm_pkg::RST_HOLD_TICKS;
            for (int i = 0; i < CHANNELS; i++) begin
                r_bar[i]  <= '0;
                r_hold[i] <= FLOOR;
            end
            r_timer     <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    apm_pkg::CFG_METER_WIDTH: r_meter_width <= i_cfg_data[PSW-1:0];
                    apm_pkg::CFG_DB_MODE: begin
                        r_db_mode <= i_cfg_data[0];
                        for (int i = 0; i < CHANNELS; i++) begin
                            r_bar[i]  <= '0;
                            r_hold[i] <= FLOOR;
                        end
                        r_timer   <= '0;
                        r_running <= 1'b0;
                    end
                    apm_pkg::CFG_HOLD_ENABLE: r_hold_en <= i_cfg_data[0];
                    apm_pkg::CFG_DECAY_STEP:  r_decay <= i_cfg_data[apm_pkg::DECAY_W-1:0];
                    apm_pkg::CFG_HOLD_TICKS:  r_hold_ticks <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.apply) begin
                r_bar[r_ch] <= w_bar;
                if (w_hold_up) begin
                    r_hold[r_ch] <= w_bar;
                    r_timer      <= '0;
                    r_running    <= 1'b1;
                end
            end
            if (i_cmd.tick && r_running) begin
                if (w_expire) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        r_hold[i] <= FLOOR;
                    end
                    r_timer   <= '0;
                    r_running <= 1'b0;
                end else begin
                    r_timer <= w_t_next;
                end
            end
            if (i_cmd.apply || (i_cmd.tick && w_expire)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/audio_peak_meter_decay_hold.sv
// Two-channel peak level meter with bar falloff and shared peak hold timer.
// Top level; depends on apm_pkg, apm_ctrl, apm_dp and assert_macros.svh.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): a level item carries
// one channel's peak as a fraction of full scale; a tick item advances the
// millisecond hold timer. One item is in work at a time; o_in_stall is low
// only while the sequencer is idle.
// Output channel (o_out_valid / i_out_stall / o_out_item): one result per
// level item of a present channel, and one per tick that expires the hold.
// From accept to result, a tick passes the decode and tick states; a linear or zero
// level passes decode, map and apply; a dB level passes decode, then the log2
// unit, scale, product, map and apply. The log2 unit normalizes the mantissa one
// bit at a time, then makes 16 squarings on one 31 x 31 multiplier, each followed
// by an accumulate step.
// A finished result sits in the output register while the next item is
// accepted; a stalled receiver holds that result and blocks the next one.
// Configuration (i_cfg_valid / o_cfg_ready) is taken only while idle.
// Reset loads register defaults, clears bars, sets holds to 3, stops the timer.
`default_nettype none
`include "assert_macros.svh"

module audio_peak_meter_decay_hold #(
    parameter int CHANNELS = 2
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire apm_pkg::t_in_item              i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output apm_pkg::t_out_item                  o_out_item,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [apm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [apm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    apm_pkg::t_dp_cmd  w_cmd;
    apm_pkg::t_dp_stat w_stat;
    logic              w_cfg_we;

    assign w_cfg_we = i_cfg_valid && o_cfg_ready;

    apm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_stat      (w_stat),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    apm_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd))
    `ASSERT_IMP(a_hold_reset_form, i_clk, i_rst_n,
        o_out_valid && o_out_item.hold_reset,
        o_out_item.bar_pos == '0 && !o_out_item.out_channel &&
        o_out_item.hold_pos == apm_pkg::POS_W'(apm_pkg::HOLD_FLOOR))
    `ASSERT_NXT(a_result_held, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

endmodule

`default_nettype wire

>>> bench/audio_peak_meter_decay_hold_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for audio_peak_meter_decay_hold: directed items, then random phases
// under changing register settings, checked item by item against an in-bench meter model.
// Depends on apm_pkg and the meter RTL.

module audio_peak_meter_decay_hold_tb;
    import apm_pkg::*;

    localparam int QUIET_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 250;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic [POS_W-1:0]   cfg_width;
    logic               cfg_db;
    logic               cfg_hold_en;
    logic [DECAY_W-1:0] cfg_decay;
    logic [TIMER_W-1:0] cfg_hold_ticks;

    logic [POS_W-1:0]   bar_lvl [2];
    logic [POS_W-1:0]   hold_lvl [2];
    logic [TIMER_W-1:0] hold_cnt;
    logic               hold_run;

    t_in_item  item_feed_q[$];
    t_out_item meter_readout_q[$];

    int items_queued   = 0;
    int items_taken    = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int gap_max        = 0;
    int stall_mode     = 0;
    int stall_phase    = 0;
    int holdoff_left   = 0;
    int tick_pct       = 30;
    logic [LEVEL_W-1:0] env_lvl [2] = '{'0, '0};

    always #5 i_clk = ~i_clk;

    audio_peak_meter_decay_hold uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic void clear_holds();
        hold_lvl[0] = POS_W'(HOLD_FLOOR);
        hold_lvl[1] = POS_W'(HOLD_FLOOR);
        hold_cnt    = '0;
        hold_run    = 1'b0;
    endfunction

    function automatic void reset_meter_model();
        cfg_width      = RST_METER_WIDTH;
        cfg_db         = 1'b0;
        cfg_hold_en    = 1'b1;
        cfg_decay      = RST_DECAY_STEP;
        cfg_hold_ticks = RST_HOLD_TICKS;
        bar_lvl[0]     = '0;
        bar_lvl[1]     = '0;
        clear_holds();
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_METER_WIDTH: cfg_width = val[POS_W-1:0];
            CFG_DB_MODE: begin
                cfg_db     = val[0];
                bar_lvl[0] = '0;
                bar_lvl[1] = '0;
                clear_holds();
            end
            CFG_HOLD_ENABLE: cfg_hold_en = val[0];
            CFG_DECAY_STEP:  cfg_decay = val[DECAY_W-1:0];
            CFG_HOLD_TICKS:  cfg_hold_ticks = val[TIMER_W-1:0];
            default: ;
        endcase
    endfunction

    // log2 of level / full scale in Q16, for a nonzero level up to full scale
    function automatic longint level_log2_q16(input longint unsigned lvl);
        int              e;
        int              i;
        longint unsigned m;
        longint          frac;
        e    = 0;
        frac = 0;
        while (e < 62 && (lvl >> (e + 1)) != 0)
            e++;
        m = lvl << (MANT_Q - e);
        for (i = 1; i <= FRAC_BITS; i++) begin
            m = (m * m) >> MANT_Q;
            if (m >= (64'd1 << (MANT_Q + 1))) begin
                m = m >> 1;
                frac = frac | (longint'(1) << (FRAC_BITS - i));
            end
        end
        return longint'(e - LEVEL_BITS) * 65536 + frac;
    endfunction

    function automatic logic [POS_W-1:0] level_to_pos(input logic [LEVEL_W-1:0] lvl_in,
                                                      input logic [POS_W-1:0] span_in);
        longint unsigned lvl;
        longint unsigned span;
        longint          s;
        longint          n;
        lvl  = lvl_in;
        span = span_in;
        if (lvl > (64'd1 << LEVEL_BITS))
            lvl = 64'd1 << LEVEL_BITS;
        if (!cfg_db)
            return POS_W'((lvl * span) >> LEVEL_BITS);
        if (lvl == 0)
            return '0;
        s = longint'(span);
        n = s * (longint'(1) << LOG_SHIFT) + s * level_log2_q16(lvl) * longint'(LOG_K_Q20);
        if (n < 0)
            return POS_W'(HOLD_FLOOR);
        return POS_W'(n >>> LOG_SHIFT);
    endfunction

    function automatic bit meter_update(input t_in_item it, output t_out_item res);
        logic [TIMER_W-1:0] lim;
        logic [POS_W-1:0]   span;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   old;
        logic [POS_W-1:0]   dropped;
        logic [POS_W-1:0]   bar;
        res = '0;
        if (it.kind == KIND_TICK) begin
            lim = (cfg_hold_ticks == 0) ? TIMER_W'(1) : cfg_hold_ticks;
            if (!hold_run)
                return 1'b0;
            hold_cnt = hold_cnt + 1'b1;
            if (hold_cnt < lim)
                return 1'b0;
            clear_holds();
            res.hold_pos   = POS_W'(HOLD_FLOOR);
            res.hold_reset = 1'b1;
            return 1'b1;
        end
        span = (cfg_width > MARGIN_PX) ? cfg_width - POS_W'(MARGIN_PX) : '0;
        pos  = level_to_pos(it.level, span);
        old  = bar_lvl[it.channel];
        if (pos >= old) begin
            bar = pos;
        end else begin
            dropped = (old > cfg_decay) ? old - cfg_decay : '0;
            bar     = (dropped > pos) ? dropped : pos;
        end
        bar_lvl[it.channel] = bar;
        if (cfg_hold_en && bar > hold_lvl[it.channel]) begin
            hold_lvl[it.channel] = bar;
            hold_cnt             = '0;
            hold_run             = 1'b1;
        end
        res.out_channel = it.channel;
        res.bar_pos     = bar;
        res.hold_pos    = cfg_hold_en ? hold_lvl[it.channel] : '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic push_level(input logic ch, input logic [LEVEL_W-1:0] lvl);
        t_in_item it;
        it.kind    = KIND_LEVEL;
        it.channel = ch;
        it.level   = lvl;
        item_feed_q.push_back(it);
        items_queued++;
    endtask

    task automatic push_tick();
        t_in_item it;
        it.kind    = KIND_TICK;
        it.channel = 1'($urandom_range(0, 1));
        it.level   = LEVEL_W'($urandom);
        item_feed_q.push_back(it);
        items_queued++;
    endtask

    // ticks or levels: decaying envelopes with fresh attacks, noise, levels up to 80
    task automatic push_random_item();
        logic               ch;
        int                 pick;
        logic [LEVEL_W-1:0] lvl;
        if ($urandom_range(0, 99) < tick_pct) begin
            push_tick();
            return;
        end
        ch   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
            if (pick == 0 || env_lvl[ch] == 0)
                env_lvl[ch] = LEVEL_W'($urandom_range(0, 65536) >> $urandom_range(0, 16));
            else
                env_lvl[ch] = env_lvl[ch] - LEVEL_W'(env_lvl[ch] / $urandom_range(3, 16));
            lvl = env_lvl[ch];
        end else if (pick < 13) begin
            lvl = LEVEL_W'($urandom);
        end else if (pick < 16) begin
            lvl = LEVEL_W'($urandom_range(0, 80));
        end else begin
            lvl = LEVEL_W'($urandom_range(0, 65536) >> $urandom_range(0, 16));
        end
        push_level(ch, lvl);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        apply_cfg(idx, CFG_DATA_W'(val));
        @(negedge i_clk);
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (items_taken != items_queued || meter_readout_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic pick_config(input int ph);
        int w;
        if (ph == 0) begin
            write_reg(CFG_DECAY_STEP, 0);
            write_reg(CFG_HOLD_TICKS, 65535);
            write_reg(CFG_METER_WIDTH, 7);
            write_reg(CFG_HOLD_ENABLE, 1);
            return;
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0:       w = $urandom_range(0, 6);
                1:       w = 1023;
                2:       w = 7;
                default: w = $urandom_range(1, 1023);
            endcase
            write_reg(CFG_METER_WIDTH, w);
        end
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_DB_MODE, $urandom_range(0, 1));
        if ($urandom_range(0, 1))
            write_reg(CFG_HOLD_ENABLE, ($urandom_range(0, 3) != 0) ? 1 : 0);
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
                0:       w = 0;
                1:       w = 255;
                2:       w = $urandom_range(1, 8);
                default: w = $urandom_range(0, 255);
            endcase
            write_reg(CFG_DECAY_STEP, w);
        end
        case ($urandom_range(0, 6))
            0:       w = 0;
            1:       w = 1;
            2:       w = 65535;
            default: w = $urandom_range(2, 40);
        endcase
        write_reg(CFG_HOLD_TICKS, w);
    endtask

    always @(posedge i_clk) begin : feed_items
        t_out_item res;
        logic      nxt_valid;
        t_in_item  nxt_item;
        if (i_rst_n) begin
            nxt_valid = i_in_valid;
            nxt_item  = i_in_item;
            if (i_in_valid && !o_in_stall) begin
                if (meter_update(i_in_item, res))
                    meter_readout_q.push_back(res);
                items_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (item_feed_q.size() > 0) begin
                    nxt_item  = item_feed_q.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end else begin
                        burst_left--;
                    end
                end
            end
            i_in_valid <= nxt_valid;
            i_in_item  <= nxt_item;
        end
    end

    always @(posedge i_clk) begin : pace_receiver
        logic nxt;
        if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            nxt = 1'b1;
        end else begin
            case (stall_mode)
                0:       nxt = 1'b0;
                1:       nxt = ($urandom_range(0, 3) == 0);
                2:       nxt = ($urandom_range(0, 3) != 0);
                default: nxt = (stall_phase % 11) < 4;
            endcase
        end
        stall_phase <= stall_phase + 1;
        i_out_stall <= nxt;
    end

    always @(posedge i_clk) begin : check_readout
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (meter_readout_q.size() == 0) begin
                report_mismatch("bar_pos of unrequested result", o_out_item.bar_pos, -1);
            end else begin
                want = meter_readout_q.pop_front();
                if (o_out_item.out_channel !== want.out_channel)
                    report_mismatch("out_channel", o_out_item.out_channel, want.out_channel);
                if (o_out_item.bar_pos !== want.bar_pos)
                    report_mismatch("bar_pos", o_out_item.bar_pos, want.bar_pos);
                if (o_out_item.hold_pos !== want.hold_pos)
                    report_mismatch("hold_pos", o_out_item.hold_pos, want.hold_pos);
                if (o_out_item.hold_reset !== want.hold_reset)
                    report_mismatch("hold_reset", o_out_item.hold_reset, want.hold_reset);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("audio_peak_meter_decay_hold regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_phases
        int ph;
        int n;
        reset_meter_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_level(1'b0, '0);
        push_level(1'b1, FULL_SCALE);
        push_level(1'b0, '1);
        push_level(1'b0, LEVEL_W'(1));
        push_level(1'b1, LEVEL_W'(32768));
        push_tick();
        push_level(1'b0, LEVEL_W'(65535));
        settle();

        // zero hold time expires on the first running tick
        write_reg(CFG_HOLD_TICKS, 0);
        write_reg(CFG_DECAY_STEP, 255);
        push_level(1'b0, FULL_SCALE);
        push_tick();
        push_tick();
        push_level(1'b1, '0);
        settle();

        write_reg(CFG_METER_WIDTH, 1023);
        write_reg(CFG_DB_MODE, 1);
        push_level(1'b0, '0);
        push_level(1'b0, LEVEL_W'(1));
        push_level(1'b0, LEVEL_W'(65));
        push_level(1'b1, LEVEL_W'(66));
        push_level(1'b0, FULL_SCALE);
        push_level(1'b1, '1);
        push_level(1'b1, LEVEL_W'(32768));
        settle();

        // timer keeps running with hold disabled
        write_reg(CFG_HOLD_ENABLE, 0);
        push_tick();
        push_level(1'b1, LEVEL_W'(40000));
        settle();

        // width change keeps the bars
        write_reg(CFG_METER_WIDTH, 0);
        push_level(1'b0, '0);
        push_level(1'b1, FULL_SCALE);
        settle();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick_config(ph);
            stall_mode = (ph == 0) ? 0 : $urandom_range(0, 3);
            case ((ph == 0) ? 0 : $urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 4;
                default: gap_max = 70;
            endcase
            tick_pct = $urandom_range(5, 45);
            if (ph == 3)
                holdoff_left = HOLDOFF_CYCLES;
            for (n = 0; n < PHASE_ITEMS; n++)
                push_random_item();
            settle();
        end

        if (mismatch_count == 0)
            $display("audio_peak_meter_decay_hold regression: pass");
        else
            $display("audio_peak_meter_decay_hold regression: fail");
        $finish;
    end

endmodule
